// ----- rtl/core/adcseg_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adcseg_pkg
// Shared constants, types and the digit glyph function for the converter
// sample to two-digit seven-segment display block.
// ---------------------------------------------------------------------------
package adcseg_pkg;

  // Sample and magnitude widths
  localparam int unsigned SampleW = 10;
  localparam int unsigned MagW    = 11;
  localparam int unsigned SpanW   = 9;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned SegW    = 8;

  // Stream data widths (fields padded up to whole bytes)
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  // Piecewise scale: knee, output limit, and reciprocal constants.
  // Quotient of 890*t/411 (or /412) equals (t*Recip) >> RecipShift for
  // every t the sample range can produce.
  localparam logic [MagW-1:0] Knee       = MagW'(100);
  localparam logic [MagW-1:0] MagLimit   = MagW'(990);
  localparam int unsigned     RecipW     = 20;
  localparam int unsigned     RecipShift = 18;
  localparam logic [RecipW-1:0] RecipPos = RecipW'(567660);
  localparam logic [RecipW-1:0] RecipNeg = RecipW'(566282);

  // Decimal point / minus sign bit
  localparam logic [SegW-1:0] DotBit = SegW'(8'h01);

  // Scaled value handed from the scale stage to the digit stage
  typedef struct packed {
    logic            negative;
    logic [MagW-1:0] mag;
  } scale_t;

  // Segment pattern of one decimal digit, bits 7..1 are GFEDCBA
  function automatic logic [SegW-1:0] glyph(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] seg;
    case (digit)
      4'd0:    seg = 8'b0111_1110;
      4'd1:    seg = 8'b0000_1100;
      4'd2:    seg = 8'b1011_0110;
      4'd3:    seg = 8'b1001_1110;
      4'd4:    seg = 8'b1100_1100;
      4'd5:    seg = 8'b1101_1010;
      4'd6:    seg = 8'b1111_1010;
      4'd7:    seg = 8'b0000_1110;
      4'd8:    seg = 8'b1111_1110;
      4'd9:    seg = 8'b1101_1110;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

// ----- rtl/core/adcseg_scale.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adcseg_scale
// Removes the midscale offset from a sample and applies the piecewise
// scale outside the +-100 band; yields sign and magnitude.
// ---------------------------------------------------------------------------
module adcseg_scale
  import adcseg_pkg::*;
(
  input  logic [SampleW-1:0] sample_i,
  output scale_t             scale_o
);

  logic                    negative;
  logic [SampleW-1:0]      abs_d;
  logic [MagW-1:0]         abs_ext;
  logic                    above_knee;
  logic [SpanW-1:0]        span;
  logic [RecipW-1:0]       recip;
  logic [SpanW+RecipW-1:0] product;
  logic [MagW-1:0]         quot;

  // Sign and absolute offset from midscale (512 itself is zero)
  assign negative = ~sample_i[SampleW-1];
  assign abs_d    = negative ? ({1'b1, {(SampleW-1){1'b0}}} - sample_i)
                             : {1'b0, sample_i[SampleW-2:0]};
  assign abs_ext  = {1'b0, abs_d};

  // Distance past the knee on either side
  assign above_knee = (abs_ext >= Knee);
  assign span       = SpanW'(abs_ext - Knee);
  assign recip      = negative ? RecipNeg : RecipPos;

  // Constant division by reciprocal multiply
  assign product = {{RecipW{1'b0}}, span} * {{SpanW{1'b0}}, recip};
  assign quot    = product[RecipShift +: MagW];

  always_comb begin
    scale_o.negative = negative;
    if (above_knee) begin
      scale_o.mag = Knee + quot;
    end else begin
      scale_o.mag = abs_ext;
    end
  end

endmodule

// ----- rtl/core/adcseg_digits.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adcseg_digits
// Splits the scaled magnitude into two decimal digits and builds both
// segment patterns, with decimal point and minus sign.
// ---------------------------------------------------------------------------
module adcseg_digits
  import adcseg_pkg::*;
(
  input  scale_t          scale_i,
  output logic            in_range_o,
  output logic [SegW-1:0] low_seg_o,
  output logic [SegW-1:0] high_seg_o
);

  logic [MagW-2:0]   mag;
  logic [17:0]       mag_x205;
  logic [6:0]        mag_div10;
  logic [6:0]        mag_mod10;
  logic [15:0]       mag_x41;
  logic [3:0]        mag_div100;
  logic [6:0]        rem100;
  logic [14:0]       rem_x205;
  logic [3:0]        rem_div10;
  logic [SegW-1:0]   low_seg;
  logic [SegW-1:0]   high_seg;

  assign mag        = scale_i.mag[MagW-2:0];
  assign in_range_o = (scale_i.mag <= MagLimit);

  // Divide by ten: exact for any 10-bit value
  assign mag_x205  = 18'(mag) * 18'd205;
  assign mag_div10 = mag_x205[17:11];
  assign mag_mod10 = 7'(mag - 10'(mag_div10) * 10'd10);

  // Divide by one hundred, then tens of the remainder
  assign mag_x41    = 16'(mag) * 16'd41;
  assign mag_div100 = mag_x41[15:12];
  assign rem100     = 7'(mag - 10'(mag_div100) * 10'd100);
  assign rem_x205   = 15'(rem100) * 15'd205;
  assign rem_div10  = rem_x205[14:11];

  // Units.tenths below 100, tens and units otherwise
  always_comb begin
    if (mag < 10'd100) begin
      low_seg  = glyph(mag_mod10[3:0]) | DotBit;
      high_seg = glyph(mag_div10[3:0]);
    end else begin
      low_seg  = glyph(rem_div10);
      high_seg = glyph(mag_div100);
    end
  end

  assign low_seg_o  = low_seg;
  assign high_seg_o = scale_i.negative ? (high_seg | DotBit) : high_seg;

endmodule

// ----- rtl/core/adc_to_two_digit_segment_display.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adc_to_two_digit_segment_display
// Converts a raw 10-bit converter sample into two seven-segment digit
// patterns and flags when the displayed pair changes.
// ---------------------------------------------------------------------------
// Each item is one sample; one result item comes out per sample. The block is
// a two-stage pipeline: the offset removal and piecewise scale (one reciprocal
// multiply) are registered into the first stage, and the digit split, segment
// lookup and change compare are registered into the output stage. A sample
// accepted into the first stage moves on into the output stage when that stage is
// empty or its item is being taken, and is offered on the output from there; one item can be accepted
// every cycle, and the whole pipeline holds only while the output item waits.
// ---------------------------------------------------------------------------
module adc_to_two_digit_segment_display
  import adcseg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: [9:0] adc_sample
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tdata: [0] in_range, [8:1] low_digit_segments,
  //        [16:9] high_digit_segments, [17] update_needed
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  scale_t          scale;
  scale_t          s1_q;
  logic            s1_valid_q;
  logic            out_valid_q;
  logic            out_advance;
  logic            s1_advance;
  logic            in_range;
  logic [SegW-1:0] low_seg;
  logic [SegW-1:0] high_seg;
  logic            changed;
  logic            in_range_q;
  logic [SegW-1:0] low_seg_q;
  logic [SegW-1:0] high_seg_q;
  logic            update_q;
  logic [SegW-1:0] last_low_q;
  logic [SegW-1:0] last_high_q;

  // Pipeline flow: output moves when empty or taken, stage 1 when it can pass on
  assign out_advance     = ~out_valid_q | m_axis_tready_i;
  assign s1_advance      = ~s1_valid_q | out_advance;
  assign s_axis_tready_o = s1_advance;

  adcseg_scale u_scale (
    .sample_i (s_axis_tdata_i[SampleW-1:0]),
    .scale_o  (scale)
  );

  // Stage 1: hold the scaled sign and magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_advance) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s_axis_tvalid_i) begin
      s1_q <= scale;
    end
  end

  adcseg_digits u_digits (
    .scale_i    (s1_q),
    .in_range_o (in_range),
    .low_seg_o  (low_seg),
    .high_seg_o (high_seg)
  );

  assign changed = (low_seg != last_low_q) || (high_seg != last_high_q);

  // Output stage and last requested patterns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_low_q  <= '0;
      last_high_q <= '0;
    end else if (out_advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q && in_range && changed) begin
        last_low_q  <= low_seg;
        last_high_q <= high_seg;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_advance && s1_valid_q) begin
      in_range_q <= in_range;
      if (in_range) begin
        low_seg_q  <= low_seg;
        high_seg_q <= high_seg;
        update_q   <= changed;
      end else begin
        low_seg_q  <= last_low_q;
        high_seg_q <= last_high_q;
        update_q   <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, update_q, high_seg_q, low_seg_q, in_range_q};

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the converter sample to two-digit display block.
// ---------------------------------------------------------------------------
// Samples are streamed in with random gaps, and the output side stalls at
// random. One long output hold-off backs the pipeline up into its input. A
// local predictor scales each sample and builds the expected digit patterns.
// It keeps its own copy of the last shown pair to predict the change flag.
// Each result item is checked field by field against the oldest expectation.
// ---------------------------------------------------------------------------
module tb_top;
  import adcseg_pkg::*;

  localparam int          HalfPeriod    = 6;
  localparam int          MaxGap        = 11;
  localparam int          HoldCycles    = 300;
  localparam int          WatchdogLimit = 2000;
  localparam int          DrainCycles   = 10;
  localparam int          Midscale      = 512;
  localparam int          KneeValue     = 100;
  localparam int          SpanOut       = 890;
  localparam int          SpanPos       = 411;
  localparam int          SpanNeg       = 412;
  localparam int          MagMax        = 990;
  localparam logic [9:0]  SampleMax     = 10'd1023;

  // Result item as packed on the output tdata, lowest field last
  typedef struct packed {
    logic            update;
    logic [SegW-1:0] high;
    logic [SegW-1:0] low;
    logic            in_range;
  } display_t;

  // Segment patterns of the decimal digits, bits 7..1 are GFEDCBA
  localparam logic [SegW-1:0] DigitSeg [10] = '{
    8'h7e, 8'h0c, 8'hb6, 8'h9e, 8'hcc, 8'hda, 8'hfa, 8'h0e, 8'hfe, 8'hde
  };

  logic                clk;
  logic                rst_n;
  logic                s_valid;
  logic                s_ready;
  logic [InDataW-1:0]  s_data;
  logic                m_valid;
  logic                m_ready;
  logic [OutDataW-1:0] m_data;

  // Predictor state: the pair last shown on the display
  logic [SegW-1:0] shown_low;
  logic [SegW-1:0] shown_high;
  display_t        pending_displays[$];

  int  mismatches;
  int  samples_sent;
  int  displays_checked;
  int  updates_seen;
  bit  feed_burst;
  bit  sink_burst;
  bit  hold_off_req;

  adc_to_two_digit_segment_display u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    clk = 1'b0;
    forever #HalfPeriod clk = ~clk;
  end

  // Scale one sample and build the expected display, advancing the shown pair
  function automatic display_t predict_display(input logic [SampleW-1:0] sample);
    int       offset;
    int       mag;
    logic     negative;
    display_t exp_item;
    offset   = int'(sample) - Midscale;
    negative = offset < 0;
    if (offset >= KneeValue) begin
      mag = KneeValue + (SpanOut * (offset - KneeValue)) / SpanPos;
    end else if (offset <= -KneeValue) begin
      mag = KneeValue + (SpanOut * (-offset - KneeValue)) / SpanNeg;
    end else begin
      mag = negative ? -offset : offset;
    end
    if (mag > MagMax) begin
      // Out of range: report the stored pair and leave it untouched
      exp_item.in_range = 1'b0;
      exp_item.low      = shown_low;
      exp_item.high     = shown_high;
      exp_item.update   = 1'b0;
      return exp_item;
    end
    if (mag < 100) begin
      exp_item.low  = DigitSeg[mag % 10] | DotBit;
      exp_item.high = DigitSeg[mag / 10];
    end else begin
      exp_item.low  = DigitSeg[(mag % 100) / 10];
      exp_item.high = DigitSeg[mag / 100];
    end
    if (negative) exp_item.high = exp_item.high | DotBit;
    exp_item.in_range = 1'b1;
    exp_item.update   = (exp_item.low != shown_low) || (exp_item.high != shown_high);
    shown_low  = exp_item.low;
    shown_high = exp_item.high;
    return exp_item;
  endfunction

  // Compare one result item with the oldest expectation
  function automatic void check_display(input logic [OutDataW-1:0] word);
    display_t got;
    display_t want;
    got = display_t'(word[$bits(display_t)-1:0]);
    displays_checked++;
    if (got.update) updates_seen++;
    if (pending_displays.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result item, expected none, actual %h", $time, word);
      return;
    end
    want = pending_displays.pop_front();
    if (got.in_range !== want.in_range) begin
      mismatches++;
      $display("%0t: in_range expected %b actual %b", $time, want.in_range, got.in_range);
    end
    if (got.low !== want.low) begin
      mismatches++;
      $display("%0t: low_digit_segments expected %h actual %h", $time, want.low, got.low);
    end
    if (got.high !== want.high) begin
      mismatches++;
      $display("%0t: high_digit_segments expected %h actual %h", $time, want.high,
               got.high);
    end
    if (got.update !== want.update) begin
      mismatches++;
      $display("%0t: update_needed expected %b actual %b", $time, want.update, got.update);
    end
  endfunction

  // Offer one sample after a random gap and hold it until accepted
  task automatic send_sample(input logic [SampleW-1:0] sample);
    int gap;
    gap = feed_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= InDataW'(sample);
    pending_displays.push_back(predict_display(sample));
    do @(posedge clk); while (!s_ready);
    samples_sent++;
  endtask

  // Result side: take items, stall at random, and serve hold-off requests
  initial begin : result_sink
    int stall;
    int hold_left;
    stall     = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_valid && m_ready) begin
        check_display(m_data);
        stall = sink_burst ? 0 : $urandom_range(0, MaxGap);
      end
      if (hold_off_req) begin
        hold_left    = HoldCycles;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // End the run when nothing moves on either side for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
      else idle++;
      if (idle >= WatchdogLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, idle);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Extremes, knee points on both sides, zero and small negative values
  task automatic test_directed();
    logic [SampleW-1:0] samples[$];
    samples = '{10'd0, SampleMax, 10'd512, 10'd511, 10'd513, 10'd611, 10'd612,
                10'd613, 10'd411, 10'd412, 10'd413, 10'd413, 10'd502, 10'd503,
                10'd521, 10'd1, 10'd1022, 10'd768, 10'd256, 10'd562, 10'd462,
                10'd512, 10'd512};
    foreach (samples[i]) send_sample(samples[i]);
  endtask

  // Nearby and repeated samples so the shown pair often stays the same
  task automatic test_repeated_samples();
    int level;
    level = $urandom_range(0, SampleMax);
    repeat (40) begin
      level += $urandom_range(0, 6) - 3;
      if (level < 0) level = 0;
      if (level > SampleMax) level = SampleMax;
      send_sample(SampleW'(level));
    end
  endtask

  // Hold the output off for a long stretch while samples keep coming
  task automatic test_output_hold_off();
    feed_burst   = 1'b1;
    hold_off_req = 1'b1;
    repeat (30) send_sample(SampleW'($urandom_range(0, SampleMax)));
    feed_burst = 1'b0;
  endtask

  // Blocks of uniform samples, slow walks and repeats with changing idle modes
  task automatic test_random_mix();
    int level;
    int kind;
    level = Midscale;
    repeat (460) begin
      if ($urandom_range(0, 49) == 0) begin
        feed_burst = $urandom_range(0, 2) == 0;
        sink_burst = $urandom_range(0, 2) == 0;
      end
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        level = $urandom_range(0, SampleMax);
      end else if (kind < 9) begin
        level += $urandom_range(0, 20) - 10;
        if (level < 0) level = 0;
        if (level > SampleMax) level = SampleMax;
      end
      send_sample(SampleW'(level));
    end
    feed_burst = 1'b0;
    sink_burst = 1'b0;
  endtask

  initial begin : run_tests
    int wait_cycles;
    mismatches       = 0;
    samples_sent     = 0;
    displays_checked = 0;
    updates_seen     = 0;
    feed_burst       = 1'b0;
    sink_burst       = 1'b0;
    hold_off_req     = 1'b0;
    shown_low        = '0;
    shown_high       = '0;
    rst_n   <= 1'b0;
    s_valid <= 1'b0;
    s_data  <= '0;
    m_ready <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_repeated_samples();
    test_output_hold_off();
    test_random_mix();
    s_valid <= 1'b0;

    // Drain the pipeline, then allow a few more cycles for stray items
    wait_cycles = 0;
    while (pending_displays.size() != 0 && wait_cycles < WatchdogLimit) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (pending_displays.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected result items never arrived", $time,
               pending_displays.size());
    end

    $display("Sent %0d samples, checked %0d display items (%0d pattern changes).",
             samples_sent, displays_checked, updates_seen);
    $display("Covered sample extremes, knees, small negatives and a long output stall.");
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
